// ----- sv/kmd_pkg.sv -----
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types, codes and key tables for the key matrix debouncer and
// layer encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

    // Field widths fixed by the item format.
    localparam int KEY_W      = 6;
    localparam int KEY_SPAN   = 2 ** KEY_W;
    localparam int HIST_W     = 7;
    localparam int CODE_W     = 8;
    localparam int LEN_W      = 3;
    localparam int LAYER_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Default number of matrix keys.
    localparam int NUM_KEYS_DEF = 63;

    // Opcodes of an input item.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_KEY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_KEY_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_KEY_B   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LEN = 2'd3;

    // Configuration reset values.
    localparam logic [KEY_W-1:0] LAYER_KEY_RST    = 6'd4;
    localparam logic [KEY_W-1:0] LOCK_KEY_A_RST   = 6'd60;
    localparam logic [KEY_W-1:0] LOCK_KEY_B_RST   = 6'd61;
    localparam logic [LEN_W-1:0] DEBOUNCE_LEN_RST = 3'd7;

    // Layer numbers and lock codes.
    localparam logic [LAYER_W-1:0] LAYER_BASE   = 2'd0;
    localparam logic [LAYER_W-1:0] LAYER_FN     = 2'd1;
    localparam logic [LAYER_W-1:0] LAYER_LOCK_A = 2'd2;
    localparam logic [LAYER_W-1:0] LAYER_LOCK_B = 2'd3;
    localparam logic [1:0]         LOCK_NONE    = 2'd0;
    localparam logic [1:0]         LOCK_A       = 2'd1;
    localparam logic [1:0]         LOCK_B       = 2'd2;

    // Offset added to a code on a press.
    localparam logic [CODE_W-1:0] PRESS_OFFSET = 8'd128;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] key_index;
        logic             raw_level;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic              any_key_down;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0] layer_key;
        logic [KEY_W-1:0] lock_key_a;
        logic [KEY_W-1:0] lock_key_b;
        logic [LEN_W-1:0] debounce_len;
    } t_cfg;

    // Base layout, also used by the two locked layers. Entries of 0x80 mark
    // layer keys, which produce no code.
    localparam logic [CODE_W-1:0] BASE_MAP [KEY_SPAN] = '{
        8'd1,  8'd15, 8'd58, 8'd42, 8'h80, 8'd86,  8'd30, 8'd16, 8'd2,
        8'd3,  8'd17, 8'd31, 8'd44, 8'd29, 8'd45,  8'd32, 8'd18, 8'd4,
        8'd5,  8'd19, 8'd33, 8'd46, 8'd56, 8'd47,  8'd34, 8'd20, 8'd6,
        8'd7,  8'd21, 8'd35, 8'd48, 8'd57, 8'd49,  8'd36, 8'd22, 8'd8,
        8'd9,  8'd23, 8'd37, 8'd50, 8'd0,  8'd51,  8'd38, 8'd24, 8'd10,
        8'd11, 8'd25, 8'd39, 8'd52, 8'd100, 8'd53, 8'd40, 8'd26, 8'd12,
        8'd13, 8'd27, 8'd43, 8'd54, 8'd97, 8'h80,  8'h80, 8'd28, 8'd14,
        8'd0
    };

    // Function layer: digit row to F1..F10, cursor and paging keys.
    localparam logic [CODE_W-1:0] FN_MAP [KEY_SPAN] = '{
        8'd1,  8'd15,  8'd58,  8'd42, 8'h80,  8'd86,  8'd30,  8'd16,  8'd59,
        8'd60, 8'd17,  8'd31,  8'd44, 8'd29,  8'd45,  8'd32,  8'd18,  8'd61,
        8'd62, 8'd19,  8'd33,  8'd46, 8'd56,  8'd47,  8'd34,  8'd20,  8'd63,
        8'd64, 8'd21,  8'd35,  8'd48, 8'd57,  8'd49,  8'd36,  8'd22,  8'd65,
        8'd66, 8'd23,  8'd37,  8'd50, 8'd0,   8'd51,  8'd105, 8'd24,  8'd67,
        8'd68, 8'd103, 8'd108, 8'd52, 8'd100, 8'd53,  8'd106, 8'd103, 8'd12,
        8'd13, 8'd104, 8'd109, 8'd54, 8'd97,  8'h80,  8'h80,  8'd28,  8'd14,
        8'd0
    };

    // Code of a key in a layer.
    function automatic logic [CODE_W-1:0] keymap_entry(input logic [LAYER_W-1:0] layer,
                                                       input logic [KEY_W-1:0]   key);
        return (layer == LAYER_FN) ? FN_MAP[key] : BASE_MAP[key];
    endfunction

    // A key whose base entry has the top bit set drives the layer logic.
    function automatic logic is_layer_key(input logic [KEY_W-1:0] key);
        return BASE_MAP[key][CODE_W-1];
    endfunction

    // History mask for a debounce length; a length of zero acts as one.
    function automatic logic [HIST_W-1:0] hist_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] eff;
        logic [HIST_W:0]  ones;
        eff  = (len == '0) ? LEN_W'(1) : len;
        ones = ((HIST_W+1)'(1) << eff) - (HIST_W+1)'(1);
        return ones[HIST_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/kmd_ram.sv -----
// ----------------------------------------------------------------------------
// kmd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the output holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/kmd_core.sv -----
// ----------------------------------------------------------------------------
// kmd_core
// History read-modify-write pipeline, debounced key state, layer logic and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_core #(
    parameter int NUM_KEYS = kmd_pkg::NUM_KEYS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire kmd_pkg::t_cfg    i_cfg,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire kmd_pkg::t_in_item i_item,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output kmd_pkg::t_result      o_result
);

    import kmd_pkg::*;

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // Pipeline and state registers.
    logic                r_s1_valid;
    t_in_item            r_s1_item;
    logic                r_s1_fwd_hit;
    logic [HIST_W-1:0]   r_s1_fwd_data;
    logic [NUM_KEYS-1:0] r_hist_valid;
    logic [NUM_KEYS-1:0] r_down_mask;
    logic [NUM_KEYS-1:0] n_down_mask;
    logic [LAYER_W-1:0]  r_layer_select;
    logic [LAYER_W-1:0]  n_layer_select;
    logic [1:0]          r_layer_lock;
    logic [1:0]          n_layer_lock;
    logic                r_out_valid;
    t_result             r_out;

    logic                in_accept;
    logic                in_range;
    logic                in_work;
    logic [AW-1:0]       in_addr;
    logic [HIST_W-1:0]   ram_rdata;
    logic [AW-1:0]       s1_addr;
    logic                s1_go;
    logic                s1_stable;
    logic [HIST_W-1:0]   s1_mask;
    logic [HIST_W-1:0]   s1_hist;
    logic [HIST_W-1:0]   s1_shift;
    logic [HIST_W-1:0]   s1_new_hist;
    logic                s1_press;
    logic                s1_release;
    logic                s1_special;
    logic                s1_emit;
    logic [CODE_W-1:0]   s1_code;

    // A key counts as held only if it exists and its debounced state is set.
    function automatic logic key_held(input logic [NUM_KEYS-1:0] mask,
                                      input logic [KEY_W-1:0]    key);
        logic [KEY_SPAN-1:0] wide;
        wide = KEY_SPAN'(mask);
        return ({1'b0, key} < (KEY_W+1)'(NUM_KEYS)) && wide[key];
    endfunction

    // Input side: keys beyond the matrix are taken and dropped.
    assign in_accept = i_valid && !o_stall;
    assign in_range  = ({1'b0, i_item.key_index} < (KEY_W+1)'(NUM_KEYS));
    assign in_work   = in_accept && in_range;
    assign in_addr   = i_item.key_index[AW-1:0];

    // The second stage completes when the result register can take a value.
    assign s1_go   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_go;
    assign s1_addr = r_s1_item.key_index[AW-1:0];

    // History store: one read per item, and one write back when the item leaves the second stage.
    kmd_ram #(
        .WIDTH (HIST_W),
        .DEPTH (NUM_KEYS),
        .AW    (AW)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (s1_addr),
        .i_wdata (s1_new_hist),
        .i_re    (in_work),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // Debounce step. A history written in the cycle of the read is forwarded,
    // and an entry never written reads as zero.
    always_comb begin
        s1_stable  = r_down_mask[s1_addr];
        s1_mask    = hist_mask(i_cfg.debounce_len);
        s1_hist    = r_s1_fwd_hit ? r_s1_fwd_data :
                     (r_hist_valid[s1_addr] ? ram_rdata : '0);
        s1_shift   = ((s1_hist << 1) & s1_mask) | HIST_W'(r_s1_item.raw_level);
        s1_press   = 1'b0;
        s1_release = 1'b0;
        if (r_s1_item.opcode == OP_RESYNC) begin
            s1_new_hist = s1_stable ? s1_mask : '0;
        end else if (s1_stable && (s1_shift == '0)) begin
            s1_release  = 1'b1;
            s1_new_hist = '0;
        end else if (!s1_stable && (s1_shift == s1_mask)) begin
            s1_press    = 1'b1;
            s1_new_hist = s1_mask;
        end else begin
            s1_new_hist = s1_shift;
        end
    end

    // Debounced key state after this item.
    always_comb begin
        n_down_mask = r_down_mask;
        if (s1_go && s1_press) begin
            n_down_mask[s1_addr] = 1'b1;
        end else if (s1_go && s1_release) begin
            n_down_mask[s1_addr] = 1'b0;
        end
    end

    // Layer logic, run when a layer key changes state.
    assign s1_special = is_layer_key(r_s1_item.key_index);
    always_comb begin
        n_layer_select = r_layer_select;
        n_layer_lock   = r_layer_lock;
        if (s1_go && s1_special && (s1_press || s1_release)) begin
            if (key_held(n_down_mask, i_cfg.layer_key)) begin
                n_layer_select = LAYER_FN;
                n_layer_lock   = LOCK_NONE;
                if (key_held(n_down_mask, i_cfg.lock_key_a)) begin
                    n_layer_select = LAYER_LOCK_A;
                    n_layer_lock   = LOCK_A;
                end else if (key_held(n_down_mask, i_cfg.lock_key_b)) begin
                    n_layer_select = LAYER_LOCK_B;
                    n_layer_lock   = LOCK_B;
                end
            end else if (r_layer_lock == LOCK_NONE) begin
                n_layer_select = LAYER_BASE;
            end
        end
    end

    // Code lookup in the current layer.
    assign s1_emit = (s1_press || s1_release) && !s1_special;
    assign s1_code = keymap_entry(r_layer_select, r_s1_item.key_index) +
                     (s1_press ? PRESS_OFFSET : '0);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_hist_valid   <= '0;
            r_down_mask    <= '0;
            r_layer_select <= LAYER_BASE;
            r_layer_lock   <= LOCK_NONE;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= in_range;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_hist_valid[s1_addr] <= 1'b1;
            end
            r_down_mask    <= n_down_mask;
            r_layer_select <= n_layer_select;
            r_layer_lock   <= n_layer_lock;
            if (s1_go && s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, including the forwarded history for the next item.
    always_ff @(posedge i_clk) begin
        if (in_work) begin
            r_s1_item     <= i_item;
            r_s1_fwd_hit  <= s1_go && (s1_addr == in_addr);
            r_s1_fwd_data <= s1_new_hist;
        end
        if (s1_go && s1_emit) begin
            r_out.event_code   <= s1_code;
            r_out.any_key_down <= |n_down_mask;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // The input side stalls only behind an occupied second stage.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("input stalled with an empty second stage");

    // The reported flag matches the key state committed with the result.
    a_any_down_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_emit) |=> (r_out.any_key_down == (|r_down_mask)))
        else $error("any_key_down disagrees with the key state");

    // A latched layer always pairs with its lock code.
    a_lock_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_layer_lock != LOCK_NONE) |-> (r_layer_select == (r_layer_lock + 2'd1)))
        else $error("layer lock and layer select disagree");

    // An accepted press leaves the key marked as down.
    a_press_sets_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_press) |=> r_down_mask[$past(s1_addr)])
        else $error("press did not set the key state");

endmodule

`default_nettype wire

// ----- sv/key_matrix_debounce_layer_encoder.sv -----
// ----------------------------------------------------------------------------
// key_matrix_debounce_layer_encoder
// Debounces raw key matrix samples and turns accepted key changes into
// layered key codes.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_stall, i_item) carries one raw sample or one
// resync command per transaction for a single key. The output channel
// (o_valid, i_stall, o_result) carries one transaction per accepted press or
// release of an ordinary key: the mapped code, plus 128 on a press, and the
// any-key-down flag. Samples that change nothing, resyncs, layer keys and keys
// beyond the matrix give no output transaction.
// One item is accepted per cycle while o_stall is low. Its result is visible
// on o_valid after the update stage and the result register: the history
// memory read is issued at the accepting edge, and the update and the result
// register write follow. The single read-modify-write of the history memory
// per item sets this rate; a write in the cycle of the next read is forwarded.
// When the receiver stalls, the result stays in the output register and one
// more item is taken into the update stage; after that o_stall rises.
// Reset clears all key histories, key states and layers at once and loads the
// register defaults. Configuration is written through i_cfg_valid/o_cfg_ready;
// the user must write it only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_layer_encoder #(
    parameter int NUM_KEYS = kmd_pkg::NUM_KEYS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire kmd_pkg::t_in_item                 i_item,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output kmd_pkg::t_result                       o_result,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [kmd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [kmd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import kmd_pkg::*;

    t_cfg r_cfg;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.layer_key    <= LAYER_KEY_RST;
            r_cfg.lock_key_a   <= LOCK_KEY_A_RST;
            r_cfg.lock_key_b   <= LOCK_KEY_B_RST;
            r_cfg.debounce_len <= DEBOUNCE_LEN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LAYER_KEY: begin
                    r_cfg.layer_key <= i_cfg_data[KEY_W-1:0];
                end
                CFG_LOCK_KEY_A: begin
                    r_cfg.lock_key_a <= i_cfg_data[KEY_W-1:0];
                end
                CFG_LOCK_KEY_B: begin
                    r_cfg.lock_key_b <= i_cfg_data[KEY_W-1:0];
                end
                CFG_DEBOUNCE_LEN: begin
                    r_cfg.debounce_len <= i_cfg_data[LEN_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    kmd_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
